// ----- rtl/vdi_pkg.sv -----
// vdi_pkg: shared types and constants of the vertex dedup indexer
// used by vdi_cell, vertex_dedup_indexer_top and vdi_checker
`default_nettype none

package vdi_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VTX_WORDS    = 8;
    localparam int WORD_W       = 32;
    localparam int NUM_CELLS    = 8;
    localparam int OUT_IDX_W    = 10;

    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CELL_W       = $clog2(NUM_CELLS);
    localparam int ROWS         = MAX_VERTICES / NUM_CELLS;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int ROWCNT_W     = CNT_W - CELL_W;

    typedef logic [VTX_WORDS-1:0][WORD_W-1:0] t_vertex;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_chain;

    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] col;
        logic [ROW_W-1:0]  row;
        t_vertex           data;
    } t_wr_req;

endpackage

`default_nettype wire

// ----- rtl/vdi_cell.sv -----
// vdi_cell: one column of the vertex table with its own memory and comparator
// depends on vdi_pkg; chained by vertex_dedup_indexer_top
`default_nettype none

module vdi_cell (
    input  wire logic                  i_clk,
    input  wire logic [vdi_pkg::CELL_W-1:0] i_cell_id,
    input  wire vdi_pkg::t_wr_req      i_wr,
    input  wire logic                  i_rd_en,
    input  wire logic [vdi_pkg::ROW_W-1:0] i_rd_row,
    input  wire logic [vdi_pkg::ROW_W-1:0] i_cmp_row,
    input  wire logic [vdi_pkg::CNT_W-1:0] i_count,
    input  wire vdi_pkg::t_vertex      i_query,
    input  wire vdi_pkg::t_chain       i_chain,
    output vdi_pkg::t_chain            o_chain
);
    import vdi_pkg::*;

    t_vertex              r_mem [ROWS];
    t_vertex              r_rdata;
    logic [IDX_W-1:0]     entry;
    logic                 my_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.col == i_cell_id)) begin
            r_mem[i_wr.row] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_row];
        end
    end

    assign entry  = {i_cmp_row, i_cell_id};
    assign my_hit = (r_rdata == i_query) && ({1'b0, entry} < i_count);

    always_comb begin
        o_chain.hit = i_chain.hit | my_hit;
        o_chain.idx = i_chain.hit ? i_chain.idx : entry;
    end

endmodule

`default_nettype wire

// ----- rtl/vertex_dedup_indexer_top.sv -----
// vertex_dedup_indexer_top: request handshake, scan control and result register
// depends on vdi_pkg and vdi_cell
`default_nettype none

// Returns one index per vertex request: the index of an identical vertex seen
// since the last mesh start, or the next free index with is_new set, or, when
// the table is full, the last index with table_full set. The table is spread
// over eight cells; each cycle every cell reads one row of its memory and
// compares it with the request, so a lookup scans eight stored vertices per
// cycle. A request scans m rows: ceil(n/8) on a miss, n being the number of
// distinct vertices held after any mesh start, or the rows up to and including
// the matching one on a hit. One request is in the scan at a time. A finished
// result sits in the output register, so the next request is taken while it
// waits; a request finishing behind a stalled result waits in its last cycle
// until the result is taken. Memory contents need no clearing after reset.
module vertex_dedup_indexer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mesh_start,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    input  wire logic [31:0] i_tex_u,
    input  wire logic [31:0] i_tex_v,
    input  wire logic [31:0] i_norm_x,
    input  wire logic [31:0] i_norm_y,
    input  wire logic [31:0] i_norm_z,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [vdi_pkg::OUT_IDX_W-1:0] o_out_index,
    output logic             o_is_new,
    output logic             o_table_full,
    output logic [31:0]      o_out_pos_x,
    output logic [31:0]      o_out_pos_y,
    output logic [31:0]      o_out_pos_z,
    output logic [31:0]      o_out_tex_u,
    output logic [31:0]      o_out_tex_v,
    output logic [31:0]      o_out_norm_x,
    output logic [31:0]      o_out_norm_y,
    output logic [31:0]      o_out_norm_z
);
    import vdi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    t_vertex               r_q, n_q;
    logic [ROWCNT_W-1:0]   r_issue_row, n_issue_row;
    logic                  r_pend, n_pend;
    logic [ROW_W-1:0]      r_pend_row, n_pend_row;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_found_idx, n_found_idx;
    logic                  r_out_valid, n_out_valid;
    logic [IDX_W-1:0]      r_out_index, n_out_index;
    logic                  r_out_new, n_out_new;
    logic                  r_out_full, n_out_full;
    t_vertex               r_out_vtx, n_out_vtx;

    logic                  in_acc;
    logic                  out_free;
    logic [ROWCNT_W-1:0]   rows_used;
    logic [CNT_W-1:0]      count_round;
    logic                  rd_en;
    logic                  scan_hit;
    t_wr_req               wr;
    t_chain                chain [NUM_CELLS+1];

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign count_round = r_count + CNT_W'(NUM_CELLS - 1);
    assign rows_used   = count_round[CNT_W-1:CELL_W];
    assign scan_hit    = r_pend && chain[NUM_CELLS].hit;
    assign rd_en       = (r_state == S_SCAN) && !scan_hit && (r_issue_row < rows_used);

    assign chain[0] = '{hit: 1'b0, idx: '0};

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        vdi_cell u_cell (
            .i_clk     (i_clk),
            .i_cell_id (CELL_W'(k)),
            .i_wr      (wr),
            .i_rd_en   (rd_en),
            .i_rd_row  (r_issue_row[ROW_W-1:0]),
            .i_cmp_row (r_pend_row),
            .i_count   (r_count),
            .i_query   (r_q),
            .i_chain   (chain[k]),
            .o_chain   (chain[k+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_q         = r_q;
        n_issue_row = r_issue_row;
        n_pend      = r_pend;
        n_pend_row  = r_pend_row;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_index = r_out_index;
        n_out_new   = r_out_new;
        n_out_full  = r_out_full;
        n_out_vtx   = r_out_vtx;
        wr.en       = 1'b0;
        wr.col      = r_count[CELL_W-1:0];
        wr.row      = r_count[CELL_W +: ROW_W];
        wr.data     = r_q;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_q = {i_norm_z, i_norm_y, i_norm_x, i_tex_v, i_tex_u,
                           i_pos_z, i_pos_y, i_pos_x};
                    if (i_mesh_start) begin
                        n_count = '0;
                    end
                    n_issue_row = '0;
                    n_pend      = 1'b0;
                    n_found     = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_found     = 1'b1;
                    n_found_idx = chain[NUM_CELLS].idx;
                    n_pend      = 1'b0;
                    n_state     = S_DONE;
                end else if (rd_en) begin
                    n_pend      = 1'b1;
                    n_pend_row  = r_issue_row[ROW_W-1:0];
                    n_issue_row = r_issue_row + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_vtx   = r_q;
                    n_out_new   = 1'b0;
                    n_out_full  = 1'b0;
                    if (r_found) begin
                        n_out_index = r_found_idx;
                    end else if (r_count < CNT_W'(MAX_VERTICES)) begin
                        n_out_index = r_count[IDX_W-1:0];
                        n_out_new   = 1'b1;
                        wr.en       = 1'b1;
                        n_count     = r_count + 1'b1;
                    end else begin
                        n_out_index = IDX_W'(MAX_VERTICES - 1);
                        n_out_full  = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q         <= n_q;
        r_issue_row <= n_issue_row;
        r_pend_row  <= n_pend_row;
        r_found_idx <= n_found_idx;
        r_out_index <= n_out_index;
        r_out_new   <= n_out_new;
        r_out_full  <= n_out_full;
        r_out_vtx   <= n_out_vtx;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_index  = r_out_index[OUT_IDX_W-1:0];
    assign o_is_new     = r_out_new;
    assign o_table_full = r_out_full;
    assign o_out_pos_x  = r_out_vtx[0];
    assign o_out_pos_y  = r_out_vtx[1];
    assign o_out_pos_z  = r_out_vtx[2];
    assign o_out_tex_u  = r_out_vtx[3];
    assign o_out_tex_v  = r_out_vtx[4];
    assign o_out_norm_x = r_out_vtx[5];
    assign o_out_norm_y = r_out_vtx[6];
    assign o_out_norm_z = r_out_vtx[7];

endmodule

`default_nettype wire

// ----- rtl/vdi_checker.sv -----
// vdi_checker: port-level checks of vertex_dedup_indexer_top, bound to it below
// depends on vdi_pkg
`default_nettype none

module vdi_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_ready,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [vdi_pkg::OUT_IDX_W-1:0] o_out_index,
    input  wire logic        o_is_new,
    input  wire logic        o_table_full
);
    import vdi_pkg::*;

    localparam logic [OUT_IDX_W-1:0] FULL_IDX = OUT_IDX_W'(MAX_VERTICES - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_index)
            && $stable(o_is_new) && $stable(o_table_full))
        else $error("result changed while stalled");

    a_new_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_new && o_table_full))
        else $error("result both new and full");

    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> o_out_index == FULL_IDX)
        else $error("full result not at last slot");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken during lookup");

endmodule

bind vertex_dedup_indexer_top vdi_checker u_vdi_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking testbench for vertex_dedup_indexer_top
// mirrors the per-mesh vertex table to predict index, new and full flags per request
// depends on vdi_pkg and the rtl of vertex_dedup_indexer_top
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vdi_pkg::MAX_VERTICES;
    import vdi_pkg::OUT_IDX_W;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 160;
    localparam int RANDOM_REQUESTS = 95;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
        logic [31:0] norm_x;
        logic [31:0] norm_y;
        logic [31:0] norm_z;
    } vertex_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic                 is_new;
        logic                 table_full;
        vertex_t              vtx;
    } lookup_t;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    req_start = 1'b0;
    vertex_t req_vtx = '0;
    logic    out_ready = 1'b1;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [OUT_IDX_W-1:0] o_out_index;
    logic                 o_is_new;
    logic                 o_table_full;
    logic [31:0]          o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic [31:0]          o_out_tex_u, o_out_tex_v;
    logic [31:0]          o_out_norm_x, o_out_norm_y, o_out_norm_z;

    vertex_t mesh_table [MAX_VERTICES];
    int      mesh_size = 0;
    lookup_t expected_lookups [$];
    vertex_t old_pool [$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      sink_stall = 0;
    bit      quiet = 1'b0;
    lookup_t seen, want;

    vertex_dedup_indexer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_mesh_start (req_start),
        .i_pos_x      (req_vtx.pos_x),
        .i_pos_y      (req_vtx.pos_y),
        .i_pos_z      (req_vtx.pos_z),
        .i_tex_u      (req_vtx.tex_u),
        .i_tex_v      (req_vtx.tex_v),
        .i_norm_x     (req_vtx.norm_x),
        .i_norm_y     (req_vtx.norm_y),
        .i_norm_z     (req_vtx.norm_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_index  (o_out_index),
        .o_is_new     (o_is_new),
        .o_table_full (o_table_full),
        .o_out_pos_x  (o_out_pos_x),
        .o_out_pos_y  (o_out_pos_y),
        .o_out_pos_z  (o_out_pos_z),
        .o_out_tex_u  (o_out_tex_u),
        .o_out_tex_v  (o_out_tex_v),
        .o_out_norm_x (o_out_norm_x),
        .o_out_norm_y (o_out_norm_y),
        .o_out_norm_z (o_out_norm_z)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic lookup_t predict_lookup(input logic start, input vertex_t v);
        lookup_t r;
        int      hit;
        int      k;
        hit = -1;
        if (start) begin
            mesh_size = 0;
        end
        for (k = 0; k < mesh_size && hit < 0; k++) begin
            if (mesh_table[k] == v) begin
                hit = k;
            end
        end
        r.vtx = v;
        r.is_new = 1'b0;
        r.table_full = 1'b0;
        if (hit >= 0) begin
            r.index = hit[OUT_IDX_W-1:0];
        end else if (mesh_size < MAX_VERTICES) begin
            mesh_table[mesh_size] = v;
            r.index = mesh_size[OUT_IDX_W-1:0];
            r.is_new = 1'b1;
            mesh_size++;
        end else begin
            r.index = OUT_IDX_W'(MAX_VERTICES - 1);
            r.table_full = 1'b1;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FC0_0000;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic vertex_t fresh_vertex();
        vertex_t v;
        v.pos_x = rand_word();
        v.pos_y = rand_word();
        v.pos_z = rand_word();
        v.tex_u = rand_word();
        v.tex_v = rand_word();
        v.norm_x = rand_word();
        v.norm_y = rand_word();
        v.norm_z = rand_word();
        return v;
    endfunction

    function automatic vertex_t uniform(input logic [31:0] w);
        return {8{w}};
    endfunction

    task automatic send_vertex(input logic start, input vertex_t v);
        int      gap;
        lookup_t exp_item;
        in_valid <= 1'b1;
        req_start <= start;
        req_vtx <= v;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        exp_item = predict_lookup(start, v);
        expected_lookups = {expected_lookups, exp_item};
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t ns: %s expected %h got %h", $time, what, exp_val, got_val);
            mismatches++;
        end
    endtask

    // output side: random stalls, no new ones started while quiet
    always @(posedge i_clk) begin
        if (sink_stall == 0 && !quiet && $urandom_range(0, 3) == 0) begin
            sink_stall = pick_gap();
        end
        if (sink_stall > 0) begin
            out_ready <= 1'b0;
            sink_stall--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            seen.index = o_out_index;
            seen.is_new = o_is_new;
            seen.table_full = o_table_full;
            seen.vtx = {o_out_pos_x, o_out_pos_y, o_out_pos_z, o_out_tex_u, o_out_tex_v,
                        o_out_norm_x, o_out_norm_y, o_out_norm_z};
            if (expected_lookups.size() == 0) begin
                $display("%0t ns: result with no request pending, index %h", $time,
                         seen.index);
                mismatches++;
            end else begin
                want = expected_lookups.pop_front();
                check_field("out_index", 32'(want.index), 32'(seen.index));
                check_field("is_new", 32'(want.is_new), 32'(seen.is_new));
                check_field("table_full", 32'(want.table_full), 32'(seen.table_full));
                check_field("out_pos_x", want.vtx.pos_x, seen.vtx.pos_x);
                check_field("out_pos_y", want.vtx.pos_y, seen.vtx.pos_y);
                check_field("out_pos_z", want.vtx.pos_z, seen.vtx.pos_z);
                check_field("out_tex_u", want.vtx.tex_u, seen.vtx.tex_u);
                check_field("out_tex_v", want.vtx.tex_v, seen.vtx.tex_v);
                check_field("out_norm_x", want.vtx.norm_x, seen.vtx.norm_x);
                check_field("out_norm_y", want.vtx.norm_y, seen.vtx.norm_y);
                check_field("out_norm_z", want.vtx.norm_z, seen.vtx.norm_z);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_basic_lookups();
        vertex_t v;
        int w;
        // first request after reset without mesh start
        send_vertex(1'b0, uniform(32'h0000_0000));
        send_vertex(1'b0, uniform(32'h0000_0000));
        send_vertex(1'b0, uniform(32'hFFFF_FFFF));
        send_vertex(1'b0, uniform(32'h8000_0000));
        send_vertex(1'b0, uniform(32'h0000_0000) ^ vertex_t'(1));
        send_vertex(1'b0, uniform(32'h0000_0000) ^ (vertex_t'(1) << 255));
        send_vertex(1'b0, uniform(32'h7FC0_0000));
        send_vertex(1'b0, uniform(32'h7FC0_0000));
        send_vertex(1'b0, uniform(32'hFFFF_FFFF));
        for (w = 0; w < 8; w++) begin
            v = '0;
            v[w*32 +: 32] = 32'hFFFF_FFFF;
            send_vertex(1'b0, v);
        end
        // mesh start forgets earlier vertices
        send_vertex(1'b1, uniform(32'hFFFF_FFFF));
        send_vertex(1'b0, uniform(32'h0000_0000));
        send_vertex(1'b1, uniform(32'h0000_0000));
        send_vertex(1'b1, uniform(32'h0000_0000));
        send_vertex(1'b0, uniform(32'h0000_0000));
        wait_drained();
    endtask

    task automatic test_table_overflow();
        vertex_t v;
        vertex_t last_stored;
        int k;
        for (k = 0; k < MAX_VERTICES; k++) begin
            v = fresh_vertex();
            v.pos_x = k;
            send_vertex(k == 0, v);
        end
        last_stored = mesh_table[MAX_VERTICES-1];
        for (k = 0; k < 3; k++) begin
            v = fresh_vertex();
            v.pos_x = 32'hFFFF_FFFF - k;
            send_vertex(1'b0, v);
        end
        send_vertex(1'b0, mesh_table[0]);
        send_vertex(1'b0, last_stored);
        send_vertex(1'b0, mesh_table[$urandom_range(0, MAX_VERTICES - 1)]);
        v = fresh_vertex();
        v.pos_x = 32'h8000_0400;
        send_vertex(1'b0, v);
        send_vertex(1'b1, last_stored);
        send_vertex(1'b0, last_stored);
        wait_drained();
    endtask

    task automatic test_random_meshes();
        vertex_t v;
        logic start;
        int sent;
        int mesh_len;
        int k;
        int r;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            quiet = ($urandom_range(0, 4) == 0);
            mesh_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40)
                                                    : $urandom_range(41, 200);
            for (k = 0; k < mesh_len && sent < RANDOM_REQUESTS; k++) begin
                start = (k == 0);
                r = $urandom_range(0, 99);
                if (r < 45 && mesh_size > 0 && !start) begin
                    v = mesh_table[$urandom_range(0, mesh_size - 1)];
                end else if (r < 60 && mesh_size > 0 && !start) begin
                    v = mesh_table[$urandom_range(0, mesh_size - 1)]
                        ^ (vertex_t'(1) << $urandom_range(0, 255));
                end else if (r < 65 && old_pool.size() > 0) begin
                    v = old_pool[$urandom_range(0, old_pool.size() - 1)];
                end else begin
                    v = fresh_vertex();
                    old_pool = {old_pool, v};
                    if (old_pool.size() > 64) begin
                        void'(old_pool.pop_front());
                    end
                    // stray mesh start in the middle of a mesh
                    if (r >= 65 && r < 70) begin
                        start = 1'b1;
                    end
                end
                send_vertex(start, v);
                sent++;
            end
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_lookups();
        test_table_overflow();
        test_random_meshes();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_lookups.size() != 0) begin
            $display("%0t ns: %0d requests never answered", $time, expected_lookups.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/vdi_pkg.sv
rtl/vdi_cell.sv
rtl/vertex_dedup_indexer_top.sv
rtl/vdi_checker.sv
tb/tb.sv
